/* rtl/core/gcc_pkg.sv */
// shared constants and types for the graph connectivity check
package gcc_pkg;

  // sizing of the node set and the edge ring
  localparam int MAX_NODES = 64;
  localparam int MAX_EDGES = 128;

  // fixed field widths of the ports
  localparam int FIELD_W = 6;
  localparam int CFG_W   = 7;

  // derived widths
  localparam int NODE_W     = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
  localparam int COUNT_W    = $clog2(MAX_NODES + 1);
  localparam int EDGE_IDX_W = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
  localparam int EDGE_CNT_W = $clog2(MAX_EDGES + 1);
  localparam int RANGE_W    = (FIELD_W > COUNT_W) ? FIELD_W : COUNT_W;
  localparam int CMP_W      = (COUNT_W > CFG_W) ? COUNT_W : CFG_W;

  // one stored edge: end_a in the low half, end_b in the high half
  typedef struct packed {
    logic [FIELD_W-1:0] b;
    logic [FIELD_W-1:0] a;
  } edge_t;

  // controller states
  typedef enum logic [1:0] {
    ST_LOAD,
    ST_SWEEP,
    ST_COUNT,
    ST_DONE
  } state_t;

endpackage

/* rtl/core/gcc_edge_cell.sv */
// one cell of the edge ring: holds an edge and passes it on when the ring moves
module gcc_edge_cell
  import gcc_pkg::*;
(
  input  logic  clk,
  input  logic  shift,
  input  edge_t d,
  output edge_t q
);

  // edge register, moves one place along the ring on shift
  always_ff @(posedge clk) begin
    if (shift) begin
      q <= d;
    end
  end

endmodule

/* rtl/core/graph_connectivity_check.sv */
// top level of the graph connectivity check: edge ring, reach sweep and result
//
//   channel  direction  handshake                fields
//   in       to block   in_valid / in_ready      end_a, end_b, last_edge
//   out      from block out_valid / out_ready    connected, reached_count, overflow
//   config   to block   node_count_we            node_count
//
// edges load one per cycle into a ring of MAX_EDGES cells (newest at the front)
// after the last edge the ring rotates in full passes round the ring, one edge
// checked against the reached set per cycle, until a pass adds no node
// in_ready is low from the last edge until the result is in the output register
// the output register frees the input side; a later result waits for it to drain
// synchronous reset: node count 1, no edges, only node 0 reached
module graph_connectivity_check
  import gcc_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               node_count_we,
  input  logic [CFG_W-1:0]   node_count,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [FIELD_W-1:0] end_a,
  input  logic [FIELD_W-1:0] end_b,
  input  logic               last_edge,
  output logic               out_valid,
  input  logic               out_ready,
  output logic               connected,
  output logic [CFG_W-1:0]   reached_count,
  output logic               overflow
);

  state_t                state;
  state_t                state_next;
  logic [CFG_W-1:0]      node_count_reg;
  logic [EDGE_CNT_W-1:0] edges_held;
  logic                  store_overflowed;
  logic [MAX_NODES-1:0]  reached_set;
  logic [EDGE_IDX_W-1:0] step;
  logic                  grew;
  logic [NODE_W-1:0]     idx;
  logic [COUNT_W-1:0]    count;

  edge_t                 ring_q [MAX_EDGES];
  edge_t                 ring_in;
  edge_t                 head;
  logic                  ring_shift;

  logic                  in_acc;
  logic                  store_full;
  logic                  step_last;
  logic                  idx_last;
  logic                  head_used;
  logic                  head_in_range;
  logic [NODE_W-1:0]     ia;
  logic [NODE_W-1:0]     ib;
  logic                  grow;
  logic                  done_fire;

  // configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      node_count_reg <= CFG_W'(1);
    end else if (node_count_we) begin
      node_count_reg <= node_count;
    end
  end

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_LOAD;
    end else begin
      state <= state_next;
    end
  end

  // next state and handshake
  always_comb begin
    state_next = state;
    in_ready   = 1'b0;
    done_fire  = 1'b0;
    case (state)
      ST_LOAD: begin
        in_ready = 1'b1;
        if (in_valid && last_edge) begin
          state_next = ST_SWEEP;
        end
      end
      ST_SWEEP: begin
        if (step_last && !grew && !grow) begin
          state_next = ST_COUNT;
        end
      end
      ST_COUNT: begin
        if (idx_last) begin
          state_next = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!out_valid || out_ready) begin
          done_fire  = 1'b1;
          state_next = ST_LOAD;
        end
      end
      default: begin
        state_next = ST_LOAD;
      end
    endcase
  end

  assign in_acc     = in_valid && in_ready;
  assign store_full = (edges_held == EDGE_CNT_W'(MAX_EDGES));
  assign step_last  = (step == EDGE_IDX_W'(MAX_EDGES - 1));
  assign idx_last   = (idx == NODE_W'(MAX_NODES - 1));

  // ring of edge cells, closed into a loop while sweeping
  assign head       = ring_q[MAX_EDGES-1];
  assign ring_in    = (state == ST_SWEEP) ? head : edge_t'{b: end_b, a: end_a};
  assign ring_shift = (state == ST_SWEEP) || (in_acc && !store_full);

  gcc_edge_cell u_cell_0 (
    .clk   (clk),
    .shift (ring_shift),
    .d     (ring_in),
    .q     (ring_q[0])
  );

  for (genvar i = 1; i < MAX_EDGES; i++) begin : g_ring
    gcc_edge_cell u_cell (
      .clk   (clk),
      .shift (ring_shift),
      .d     (ring_q[i-1]),
      .q     (ring_q[i])
    );
  end

  // head edge counts only while it is one of the held edges
  assign head_in_range = (RANGE_W'(head.a) < RANGE_W'(MAX_NODES)) &&
                         (RANGE_W'(head.b) < RANGE_W'(MAX_NODES));
  assign head_used     = (state == ST_SWEEP) && head_in_range &&
                         (EDGE_CNT_W'(step) >= (EDGE_CNT_W'(MAX_EDGES) - edges_held));
  assign ia            = NODE_W'(head.a);
  assign ib            = NODE_W'(head.b);
  assign grow          = head_used && (reached_set[ia] != reached_set[ib]);

  // edge count, overflow flag and reached set
  always_ff @(posedge clk) begin
    if (rst) begin
      edges_held       <= '0;
      store_overflowed <= 1'b0;
      reached_set      <= MAX_NODES'(1);
    end else if (done_fire) begin
      edges_held       <= '0;
      store_overflowed <= 1'b0;
      reached_set      <= MAX_NODES'(1);
    end else begin
      if (in_acc) begin
        if (store_full) begin
          store_overflowed <= 1'b1;
        end else begin
          edges_held <= edges_held + EDGE_CNT_W'(1);
        end
      end
      if (grow) begin
        reached_set <= reached_set | (MAX_NODES'(1) << ia) | (MAX_NODES'(1) << ib);
      end
    end
  end

  // pass step counter and growth flag
  always_ff @(posedge clk) begin
    if (rst) begin
      step <= '0;
      grew <= 1'b0;
    end else if (state == ST_SWEEP) begin
      if (step_last) begin
        step <= '0;
        grew <= 1'b0;
      end else begin
        step <= step + EDGE_IDX_W'(1);
        grew <= grew || grow;
      end
    end else begin
      step <= '0;
      grew <= 1'b0;
    end
  end

  // node count, one bit of the reached set per cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      idx   <= '0;
      count <= '0;
    end else if (state == ST_COUNT) begin
      idx   <= idx + NODE_W'(1);
      count <= count + COUNT_W'(reached_set[idx]);
    end else if (state == ST_SWEEP) begin
      idx   <= '0;
      count <= '0;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (done_fire) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (done_fire) begin
      connected     <= (CMP_W'(count) == CMP_W'(node_count_reg));
      reached_count <= CFG_W'(count);
      overflow      <= store_overflowed;
    end
  end

  // checks
  a_held_bound: assert property (@(posedge clk) disable iff (rst)
    edges_held <= EDGE_CNT_W'(MAX_EDGES))
    else $error("edge count beyond ring size");

  a_root_reached: assert property (@(posedge clk) disable iff (rst)
    reached_set[0])
    else $error("node 0 dropped from reached set");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    (state == ST_COUNT) |-> (RANGE_W'(count) <= RANGE_W'(idx)))
    else $error("node count ahead of scan index");

  a_clear_after_result: assert property (@(posedge clk) disable iff (rst)
    done_fire |=> (out_valid && (edges_held == '0) && !store_overflowed &&
                   (state == ST_LOAD)))
    else $error("graph state not cleared after result");

endmodule

/* tb/reach_checker.sv */
// checker for the graph connectivity check: tracks the edge store, predicts reach results, compares
module reach_checker
  import gcc_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               node_count_we,
  input  logic [CFG_W-1:0]   node_count,
  input  logic               in_valid,
  input  logic               in_ready,
  input  logic [FIELD_W-1:0] end_a,
  input  logic [FIELD_W-1:0] end_b,
  input  logic               last_edge,
  input  logic               out_valid,
  input  logic               out_ready,
  input  logic               connected,
  input  logic [CFG_W-1:0]   reached_count,
  input  logic               overflow,
  output int                 fail_count,
  output int                 pending,
  output int                 checked
);

  typedef struct packed {
    logic             connected;
    logic [CFG_W-1:0] reached;
    logic             overflow;
  } reach_result_t;

  // own copy of the configuration and the current graph
  logic [CFG_W-1:0] nodes_cfg;
  edge_t            edge_ring [MAX_EDGES];
  int               edges_kept;
  logic             store_full_hit;
  reach_result_t    reach_q [$];
  reach_result_t    want;

  initial begin
    fail_count = 0;
    pending    = 0;
    checked    = 0;
  end

  // flood the reached set over the kept edges until a sweep adds nothing
  function automatic reach_result_t predict_reach();
    logic [MAX_NODES-1:0] seen;
    logic                 grew;
    logic [FIELD_W-1:0]   na;
    logic [FIELD_W-1:0]   nb;
    int                   hits;
    reach_result_t        res;
    seen    = '0;
    seen[0] = 1'b1;
    grew    = 1'b1;
    while (grew) begin
      grew = 1'b0;
      for (int i = 0; i < edges_kept; i++) begin
        na = edge_ring[i].a;
        nb = edge_ring[i].b;
        if (na < MAX_NODES && nb < MAX_NODES && seen[na] != seen[nb]) begin
          seen[na] = 1'b1;
          seen[nb] = 1'b1;
          grew     = 1'b1;
        end
      end
    end
    hits          = $countones(seen);
    res.reached   = hits[CFG_W-1:0];
    res.connected = (hits == int'(nodes_cfg));
    res.overflow  = store_full_hit;
    return res;
  endfunction

  task automatic report_mismatch(input string what, input int got, input int wanted);
    $display("mismatch on result %0d, %s: got %0d, expected %0d", checked, what, got, wanted);
    fail_count++;
  endtask

  // sample both channels and the register port at the rising edge
  always @(posedge clk) begin : watch
    if (rst) begin
      nodes_cfg      = 7'd1;
      edges_kept     = 0;
      store_full_hit = 1'b0;
      reach_q.delete();
    end else begin
      if (node_count_we)
        nodes_cfg = node_count;
      // store the edge, or note that the store was full
      if (in_valid && in_ready) begin
        if (edges_kept < MAX_EDGES) begin
          edge_ring[edges_kept].a = end_a;
          edge_ring[edges_kept].b = end_b;
          edges_kept++;
        end else begin
          store_full_hit = 1'b1;
        end
        if (last_edge) begin
          reach_q.push_back(predict_reach());
          edges_kept     = 0;
          store_full_hit = 1'b0;
        end
      end
      // compare an accepted result against the oldest prediction
      if (out_valid && out_ready) begin
        if (reach_q.size() == 0) begin
          report_mismatch("unexpected result, reached_count", int'(reached_count), -1);
        end else begin
          want = reach_q.pop_front();
          if (connected !== want.connected)
            report_mismatch("connected", int'(connected), int'(want.connected));
          if (reached_count !== want.reached)
            report_mismatch("reached_count", int'(reached_count), int'(want.reached));
          if (overflow !== want.overflow)
            report_mismatch("overflow", int'(overflow), int'(want.overflow));
          checked++;
        end
      end
    end
    pending = reach_q.size();
  end

endmodule

/* tb/tb_graph_connectivity_check.sv */
// testbench top for the graph connectivity check: stimulus, output pacing and verdict
module tb_graph_connectivity_check;
  import gcc_pkg::*;

  localparam int RANDOM_ITEMS = 1150;
  localparam int PHASE_ITEMS  = 140;
  localparam int LONG_HOLD    = 1500;
  // quiet time after the last result, about one sweep pass plus the count
  localparam int SETTLE       = MAX_EDGES + MAX_NODES + 8;
  // bound covers the slowest graph's sweep passes plus the long hold-off
  localparam int QUIET_LIMIT  = 40000;

  typedef enum int {GR_TREE, GR_SPARSE, GR_NOISE} graph_kind_t;

  logic               clk           = 1'b0;
  logic               rst           = 1'b1;
  logic               node_count_we = 1'b0;
  logic [CFG_W-1:0]   node_count    = '0;
  logic               in_valid      = 1'b0;
  logic               in_ready;
  logic [FIELD_W-1:0] end_a         = '0;
  logic [FIELD_W-1:0] end_b         = '0;
  logic               last_edge     = 1'b0;
  logic               out_valid;
  logic               out_ready     = 1'b0;
  logic               connected;
  logic [CFG_W-1:0]   reached_count;
  logic               overflow;

  int    fail_count;
  int    pending;
  int    checked;
  int    edges_sent      = 0;
  int    cfg_writes      = 0;
  int    overflow_graphs = 0;
  int    hold_requests   = 0;
  int    holds_done      = 0;
  edge_t graph_edges [$];

  always #5 clk = ~clk;

  graph_connectivity_check u_dut (
    .clk           (clk),
    .rst           (rst),
    .node_count_we (node_count_we),
    .node_count    (node_count),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .end_a         (end_a),
    .end_b         (end_b),
    .last_edge     (last_edge),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .connected     (connected),
    .reached_count (reached_count),
    .overflow      (overflow)
  );

  reach_checker u_check (
    .clk           (clk),
    .rst           (rst),
    .node_count_we (node_count_we),
    .node_count    (node_count),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .end_a         (end_a),
    .end_b         (end_b),
    .last_edge     (last_edge),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .connected     (connected),
    .reached_count (reached_count),
    .overflow      (overflow),
    .fail_count    (fail_count),
    .pending       (pending),
    .checked       (checked)
  );

  // append an edge with its ends in random order
  function automatic void add_edge(input int x, input int y);
    edge_t e;
    if ($urandom_range(0, 1)) begin
      e.a = FIELD_W'(x);
      e.b = FIELD_W'(y);
    end else begin
      e.a = FIELD_W'(y);
      e.b = FIELD_W'(x);
    end
    graph_edges.push_back(e);
  endfunction

  // build one graph into graph_edges, shuffled
  task automatic make_graph(input graph_kind_t kind, input int span, input int m);
    int   order [$];
    int   j;
    int   tmp;
    edge_t e;
    graph_edges.delete();
    case (kind)
      GR_TREE: begin
        // nodes 0..m-1, node 0 first, each later node hooked to an earlier one
        for (int k = 0; k < m; k++)
          order.push_back(k);
        for (int k = m - 1; k > 1; k--) begin
          j        = $urandom_range(1, k);
          tmp      = order[k];
          order[k] = order[j];
          order[j] = tmp;
        end
        for (int k = 1; k < m; k++)
          add_edge(order[k], order[$urandom_range(0, k - 1)]);
        repeat ($urandom_range(0, 3))
          add_edge($urandom_range(0, m - 1), $urandom_range(0, m - 1));
        if (graph_edges.size() == 0)
          add_edge(0, 0);
      end
      GR_SPARSE: begin
        repeat (m)
          add_edge($urandom_range(0, span - 1), $urandom_range(0, span - 1));
      end
      default: begin
        repeat (m)
          add_edge($urandom_range(0, 63), $urandom_range(0, 63));
      end
    endcase
    for (int k = graph_edges.size() - 1; k > 0; k--) begin
      j              = $urandom_range(0, k);
      e              = graph_edges[k];
      graph_edges[k] = graph_edges[j];
      graph_edges[j] = e;
    end
  endtask

  // offer one item after a random gap and wait until it is taken
  task automatic send_edge(input logic [FIELD_W-1:0] a, input logic [FIELD_W-1:0] b,
                           input logic last);
    int r;
    int gap;
    r   = $urandom_range(0, 99);
    gap = (r < 60) ? 0 : (r < 95) ? $urandom_range(1, 3) : $urandom_range(8, 40);
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid  <= 1'b1;
    end_a     <= a;
    end_b     <= b;
    last_edge <= last;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    edges_sent++;
  endtask

  task automatic send_graph();
    for (int k = 0; k < graph_edges.size(); k++)
      send_edge(graph_edges[k].a, graph_edges[k].b, k == graph_edges.size() - 1);
  endtask

  // let every predicted result come out, then let the block go quiet
  task automatic drain_block();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  task automatic set_node_count(input logic [CFG_W-1:0] v);
    @(negedge clk);
    node_count_we <= 1'b1;
    node_count    <= v;
    @(negedge clk);
    node_count_we <= 1'b0;
    cfg_writes++;
  endtask

  // output side: random ready stretches, plus long hold-offs on request
  initial begin : result_pacing
    logic lvl;
    int   len;
    int   r;
    forever begin
      if (holds_done < hold_requests) begin
        lvl = 1'b0;
        len = LONG_HOLD;
        holds_done++;
      end else begin
        r = $urandom_range(0, 99);
        if (r < 70) begin
          lvl = 1'b1;
          len = $urandom_range(1, 20);
        end else if (r < 95) begin
          lvl = 1'b0;
          len = $urandom_range(1, 3);
        end else begin
          lvl = 1'b0;
          len = $urandom_range(10, 40);
        end
      end
      @(negedge clk);
      out_ready <= lvl;
      repeat (len - 1) @(negedge clk);
    end
  end

  // end the run when nothing has been accepted for too long
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready))
        quiet = 0;
      else
        quiet++;
    end
    $display("timeout: no item moved for %0d cycles, %0d results outstanding",
             QUIET_LIMIT, pending);
    $display("status: fail");
    $finish;
  end

  initial begin : stimulus
    int               phase;
    int               base;
    int               start;
    int               span;
    int               r;
    int               m;
    logic             first;
    logic [CFG_W-1:0] nc;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed: reset node count of one, a lone self-loop
    send_edge(6'd0, 6'd0, 1'b1);
    drain_block();
    set_node_count(7'd64);
    // top node on its own, then top node linked to node 0
    send_edge(6'd63, 6'd63, 1'b1);
    send_edge(6'd0, 6'd63, 1'b1);
    // chain given back to front, needs several passes
    send_edge(6'd63, 6'd62, 1'b0);
    send_edge(6'd62, 6'd1, 1'b0);
    send_edge(6'd1, 6'd0, 1'b1);
    drain_block();
    set_node_count(7'd2);
    send_edge(6'd1, 6'd0, 1'b1);
    // a node beyond the node count is still reached and counted
    send_edge(6'd0, 6'd5, 1'b0);
    send_edge(6'd0, 6'd1, 1'b1);
    drain_block();
    // node count of zero and above the node limit never match
    set_node_count(7'd0);
    send_edge(6'd0, 6'd1, 1'b1);
    drain_block();
    set_node_count(7'd127);
    send_edge(6'd0, 6'd1, 1'b1);
    drain_block();
    set_node_count(7'd3);
    // repeated edge and self-loop add nothing
    send_edge(6'd0, 6'd1, 1'b0);
    send_edge(6'd1, 6'd0, 1'b0);
    send_edge(6'd1, 6'd1, 1'b0);
    send_edge(6'd2, 6'd1, 1'b1);
    send_edge(6'd2, 6'd2, 1'b1);
    send_edge(6'd63, 6'd0, 1'b1);

    // random phases, each with its own node count
    base  = edges_sent;
    phase = 0;
    while (edges_sent - base < RANDOM_ITEMS) begin
      drain_block();
      case (phase % 8)
        0:       nc = 7'd64;
        1:       nc = 7'd1;
        2:       nc = CFG_W'($urandom_range(2, 63));
        3:       nc = 7'd0;
        4:       nc = 7'd127;
        5:       nc = CFG_W'($urandom_range(33, 64));
        6:       nc = CFG_W'($urandom_range(2, 16));
        default: nc = CFG_W'($urandom_range(65, 126));
      endcase
      set_node_count(nc);
      // hold the output off while graphs keep coming, so the input stalls
      if (phase % 8 == 1 || phase % 8 == 4)
        hold_requests++;
      start = edges_sent;
      first = 1'b1;
      while (edges_sent - start < PHASE_ITEMS && edges_sent - base < RANDOM_ITEMS) begin
        span = (nc >= 1 && nc <= MAX_NODES) ? int'(nc) : int'($urandom_range(1, MAX_NODES));
        if (first && phase % 8 == 2) begin
          // store filled exactly, no overflow
          make_graph(GR_SPARSE, span, MAX_EDGES);
        end else if (first && (phase % 8 == 3 || phase % 8 == 5)) begin
          // more edges than the store holds
          make_graph(GR_SPARSE, span, MAX_EDGES + $urandom_range(1, 12));
          overflow_graphs++;
        end else begin
          r = $urandom_range(0, 99);
          if (r < 45) begin
            make_graph(GR_TREE, span,
                       ($urandom_range(0, 9) < 6) ? span : $urandom_range(1, span));
          end else if (r < 80) begin
            m = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
            make_graph(GR_SPARSE, span, m);
          end else begin
            make_graph(GR_NOISE, span, $urandom_range(1, 16));
          end
        end
        first = 1'b0;
        send_graph();
      end
      phase++;
    end
    drain_block();

    $display("covered %0d edges over %0d checked graphs and %0d node-count settings",
             edges_sent, checked, cfg_writes);
    $display("including %0d over-full graphs and %0d long output hold-offs, %0d mismatches",
             overflow_graphs, holds_done, fail_count);
    if (fail_count == 0 && pending == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end

endmodule
